// ===== hdl/two_point_sensor_calibrate_rescale_unit_defines.svh =====
// Assertion helpers shared by the RTL files.
`ifndef TWO_POINT_SENSOR_CALIBRATE_RESCALE_UNIT_DEFINES_SVH
`define TWO_POINT_SENSOR_CALIBRATE_RESCALE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define TPSCR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TPSCR_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define TPSCR_ASSERT(label, clk, rst_n, prop, msg)

`define TPSCR_ASSERT_NEVER(label, clk, rst_n, prop, msg)

`endif

`endif

// ===== hdl/tpscr_pkg.sv =====
`timescale 1ns / 1ps

package tpscr_pkg;

  localparam int DATA_W     = 12;
  localparam int SENS_W     = 2;
  localparam int RAW_BITS   = 12;
  localparam int COEF_SHIFT = 11;  // coefficients are scaled by 2048
  localparam int SLOPE_W    = 25;
  localparam int OFFSET_W   = 38;
  localparam int QUOT_W     = DATA_W + COEF_SHIFT;
  localparam int PROD_W     = SLOPE_W + RAW_BITS + 1;
  localparam int SUM_W      = OFFSET_W + 1;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int NUM_SENSORS_DEFAULT = 3;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_BLACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_WHITE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND   = 2'd3;

  localparam logic [DATA_W-1:0] NOMINAL_BLACK_RESET = 12'd0;
  localparam logic [DATA_W-1:0] NOMINAL_WHITE_RESET = 12'd4095;
  localparam logic [DATA_W-1:0] LOWER_BOUND_RESET   = 12'd0;
  localparam logic [DATA_W-1:0] UPPER_BOUND_RESET   = 12'd4095;

  localparam logic OP_CALIBRATE = 1'b0;
  localparam logic OP_RESCALE   = 1'b1;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_COMMITTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd2;

  typedef struct packed {
    logic              op;
    logic [SENS_W-1:0] sensor;
    logic [DATA_W-1:0] black_raw;
    logic [DATA_W-1:0] white_raw;
    logic [DATA_W-1:0] reflected_raw;
    logic [DATA_W-1:0] ambient_raw;
    logic              last_entry;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [SENS_W-1:0]   sensor_out;
    logic [DATA_W-1:0]   rescaled_level;
    logic [DATA_W-1:0]   ambient_out;
    logic [STATUS_W-1:0] calib_status;
  } out_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] nominal_black;
    logic [DATA_W-1:0] nominal_white;
    logic [DATA_W-1:0] lower_bound;
    logic [DATA_W-1:0] upper_bound;
  } cfg_regs_t;

  // Decoded item as it travels from the front end to the back end
  typedef struct packed {
    logic                op;
    logic [SENS_W-1:0]   sensor;
    logic                in_range;
    logic                bad_pair;
    logic                last_entry;
    logic [RAW_BITS-1:0] black;
    logic [RAW_BITS-1:0] span;
    logic [RAW_BITS-1:0] reflected;
    logic [DATA_W-1:0]   ambient;
  } cmd_t;

  typedef struct packed {
    logic                start;
    logic [QUOT_W-1:0]   dividend;
    logic [RAW_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/tpscr_front.sv =====
`timescale 1ns / 1ps

module tpscr_front import tpscr_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output cmd_t     push_cmd_o,
  input  logic     push_ready_i
);

  logic                hold_q;
  cmd_t                cmd_q;
  cmd_t                cmd_d;
  logic [RAW_BITS-1:0] black;
  logic [RAW_BITS-1:0] white;
  logic                load;

  assign in_stall_o = hold_q && !push_ready_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    black            = in_item_i.black_raw[RAW_BITS-1:0];
    white            = in_item_i.white_raw[RAW_BITS-1:0];
    cmd_d.op         = in_item_i.op;
    cmd_d.sensor     = in_item_i.sensor;
    cmd_d.in_range   = int'(in_item_i.sensor) < NUM_SENSORS;
    cmd_d.bad_pair   = black >= white;
    cmd_d.last_entry = in_item_i.last_entry;
    cmd_d.black      = black;
    cmd_d.span       = white - black;
    cmd_d.reflected  = in_item_i.reflected_raw[RAW_BITS-1:0];
    cmd_d.ambient    = in_item_i.ambient_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (!in_stall_o) begin
      hold_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_d;
    end
  end

  assign push_o     = hold_q;
  assign push_cmd_o = cmd_q;

endmodule

// ===== hdl/tpscr_queue.sv =====
`timescale 1ns / 1ps
`include "two_point_sensor_calibrate_rescale_unit_defines.svh"

module tpscr_queue import tpscr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             full;
  logic             do_push;
  logic             do_pop;

  assign full         = count_q == CNT_W'(QUEUE_DEPTH);
  assign push_ready_o = !full;
  assign head_valid_o = count_q != '0;
  assign do_push      = push_i && !full;
  assign do_pop       = pop_i && head_valid_o;
  assign head_cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `TPSCR_ASSERT_NEVER(a_queue_overfill, clk_i, rst_ni, count_q > CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")

endmodule

// ===== hdl/tpscr_div.sv =====
`timescale 1ns / 1ps

module tpscr_div import tpscr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [CNT_W-1:0]    count_q;
  logic                busy_q;
  logic                done_q;
  logic [QUOT_W-1:0]   quot_q;
  logic [QUOT_W-1:0]   quot_d;
  logic [RAW_BITS-1:0] rem_q;
  logic [RAW_BITS-1:0] rem_d;
  logic [RAW_BITS-1:0] divisor_q;
  logic [RAW_BITS:0]   shifted;
  logic [RAW_BITS:0]   diff;
  logic                ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quot_q[QUOT_W-1]};
    diff    = shifted - {1'b0, divisor_q};
    ge      = shifted >= {1'b0, divisor_q};
    rem_d   = ge ? diff[RAW_BITS-1:0] : shifted[RAW_BITS-1:0];
    quot_d  = {quot_q[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= busy_q && (count_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q  <= 1'b1;
        count_q <= CNT_W'(QUOT_W);
      end else if (busy_q) begin
        count_q <= count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q    <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

// ===== hdl/tpscr_back.sv =====
`timescale 1ns / 1ps
`include "two_point_sensor_calibrate_rescale_unit_defines.svh"

module tpscr_back import tpscr_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_cmd_i,
  output logic      pop_o,
  input  cfg_regs_t cfg_i,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DIV     = 7'b0000010,
    S_CAL_MUL = 7'b0000100,
    S_CAL_OFS = 7'b0001000,
    S_RES_MUL = 7'b0010000,
    S_RES_SUM = 7'b0100000,
    S_DONE    = 7'b1000000
  } back_state_e;

  back_state_e state_q;
  back_state_e state_d;

  logic signed [SLOPE_W-1:0]  slope_tab_q      [NUM_SENSORS];
  logic signed [OFFSET_W-1:0] offset_tab_q     [NUM_SENSORS];
  logic signed [SLOPE_W-1:0]  staged_slope_q   [NUM_SENSORS];
  logic signed [OFFSET_W-1:0] staged_offset_q  [NUM_SENSORS];
  logic                       staging_valid_q;

  cmd_t                       cmd_q;
  logic                       neg_q;
  logic signed [SLOPE_W-1:0]  slope_q;
  logic signed [SLOPE_W-1:0]  slope_d;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [OFFSET_W-1:0] offset_sel_q;
  logic signed [SUM_W-1:0]    sum_q;
  out_item_t                  out_q;
  out_item_t                  out_d;
  logic                       out_valid_q;

  logic [IDX_W-1:0]           idx;
  logic                       need_div;
  logic                       slot_free;
  logic                       load_out;
  logic                       stage_ok;
  logic [DATA_W-1:0]          delta_mag;
  logic [SLOPE_W-1:0]         quot_ext;
  logic signed [SLOPE_W-1:0]  mul_a;
  logic signed [RAW_BITS:0]   mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [SLOPE_W-1:0]  tab_slope;
  logic signed [OFFSET_W-1:0] tab_offset;
  logic signed [OFFSET_W-1:0] nb_scaled;
  logic signed [OFFSET_W-1:0] offset_new;
  logic signed [SUM_W-1:0]    level_floor;
  logic signed [SUM_W-1:0]    level;
  logic signed [SUM_W-1:0]    lo_s;
  logic signed [SUM_W-1:0]    hi_s;
  logic                       round_up;
  logic [DATA_W-1:0]          level_clamped;

  assign idx       = IDX_W'(cmd_q.sensor);
  assign pop_o     = (state_q == S_IDLE) && head_valid_i;
  assign need_div  = (head_cmd_i.op == OP_CALIBRATE) && !head_cmd_i.bad_pair &&
                     head_cmd_i.in_range;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == S_DONE) && slot_free;
  assign stage_ok  = staging_valid_q && !cmd_q.bad_pair;

  // Divider takes |nominal delta| * 2048 over the raw span; sign is applied after
  always_comb begin
    delta_mag = (cfg_i.nominal_white < cfg_i.nominal_black) ?
                cfg_i.nominal_black - cfg_i.nominal_white :
                cfg_i.nominal_white - cfg_i.nominal_black;
    div_req_o.start    = pop_o && need_div;
    div_req_o.dividend = {delta_mag, {COEF_SHIFT{1'b0}}};
    div_req_o.divisor  = head_cmd_i.span;
    quot_ext = SLOPE_W'(div_rsp_i.quotient);
    slope_d  = neg_q ? -$signed(quot_ext) : $signed(quot_ext);
  end

  // One multiplier, shared by the offset and the rescale products
  always_comb begin
    tab_slope  = cmd_q.in_range ? slope_tab_q[idx] : '0;
    tab_offset = cmd_q.in_range ? offset_tab_q[idx] : '0;
    if (state_q == S_CAL_MUL) begin
      mul_a = slope_q;
      mul_b = $signed({1'b0, cmd_q.black});
    end else begin
      mul_a = tab_slope;
      mul_b = $signed({1'b0, cmd_q.reflected});
    end
    mul_p      = mul_a * mul_b;
    nb_scaled  = $signed(OFFSET_W'(cfg_i.nominal_black) << COEF_SHIFT);
    offset_new = nb_scaled - OFFSET_W'(prod_q);
  end

  // Divide by 2048 toward zero, then clamp
  always_comb begin
    level_floor = sum_q >>> COEF_SHIFT;
    round_up    = sum_q[SUM_W-1] && (sum_q[COEF_SHIFT-1:0] != '0);
    level       = level_floor + $signed({{(SUM_W-1){1'b0}}, round_up});
    lo_s        = $signed(SUM_W'(cfg_i.lower_bound));
    hi_s        = $signed(SUM_W'(cfg_i.upper_bound));
    if (level < lo_s) begin
      level_clamped = cfg_i.lower_bound;
    end else if (level > hi_s) begin
      level_clamped = cfg_i.upper_bound;
    end else begin
      level_clamped = level[DATA_W-1:0];
    end
  end

  always_comb begin
    out_d.sensor_out = cmd_q.sensor;
    if (cmd_q.op == OP_RESCALE) begin
      out_d.kind           = KIND_SAMPLE;
      out_d.rescaled_level = level_clamped;
      out_d.ambient_out    = cmd_q.ambient;
      out_d.calib_status   = STATUS_NONE;
    end else begin
      out_d.kind           = KIND_ACK;
      out_d.rescaled_level = '0;
      out_d.ambient_out    = '0;
      if (!cmd_q.last_entry) begin
        out_d.calib_status = STATUS_NONE;
      end else if (stage_ok) begin
        out_d.calib_status = STATUS_COMMITTED;
      end else begin
        out_d.calib_status = STATUS_REJECTED;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          if (head_cmd_i.op == OP_RESCALE) begin
            state_d = S_RES_MUL;
          end else if (need_div) begin
            state_d = S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          state_d = S_CAL_MUL;
        end
      end
      S_CAL_MUL: state_d = S_CAL_OFS;
      S_CAL_OFS: state_d = S_DONE;
      S_RES_MUL: state_d = S_RES_SUM;
      S_RES_SUM: state_d = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      out_valid_q     <= 1'b0;
      staging_valid_q <= 1'b1;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        slope_tab_q[i]  <= '0;
        offset_tab_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_out && (cmd_q.op == OP_CALIBRATE)) begin
        if (cmd_q.last_entry) begin
          staging_valid_q <= 1'b1;
          if (stage_ok) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
              slope_tab_q[i]  <= staged_slope_q[i];
              offset_tab_q[i] <= staged_offset_q[i];
            end
          end
        end else begin
          staging_valid_q <= stage_ok;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_cmd_i;
      neg_q <= cfg_i.nominal_white < cfg_i.nominal_black;
    end
    if ((state_q == S_DIV) && div_rsp_i.done) begin
      slope_q <= slope_d;
    end
    if ((state_q == S_CAL_MUL) || (state_q == S_RES_MUL)) begin
      prod_q <= mul_p;
    end
    if (state_q == S_RES_MUL) begin
      offset_sel_q <= tab_offset;
    end
    if (state_q == S_RES_SUM) begin
      sum_q <= SUM_W'(offset_sel_q) + SUM_W'(prod_q);
    end
    if (state_q == S_CAL_OFS) begin
      staged_slope_q[idx]  <= slope_q;
      staged_offset_q[idx] <= offset_new;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TPSCR_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_rsp_i.done |-> (state_q == S_DIV), "divider finished outside the divide state")
  `TPSCR_ASSERT(a_decision_rearms, clk_i, rst_ni, (load_out && (cmd_q.op == OP_CALIBRATE) && cmd_q.last_entry) |=> staging_valid_q, "staging not rearmed after commit decision")
  `TPSCR_ASSERT(a_ack_zero_payload, clk_i, rst_ni, (out_valid_q && (out_q.kind == KIND_ACK)) |-> ((out_q.rescaled_level == '0) && (out_q.ambient_out == '0)), "calibration ack carries sample data")

endmodule

// ===== hdl/two_point_sensor_calibrate_rescale_unit.sv =====
`timescale 1ns / 1ps

// Two-point sensor calibration and rescaling. A calibrate item (op 0) turns one sensor's
// black and white raw readings into a slope and offset scaled by 2048 and stages them; the
// item marked last commits all staged pairs if every pair since the previous decision had
// black below white, and reports committed or rejected. A rescale item (op 1) maps the
// reflected reading through the committed coefficients, truncates toward zero, clamps to
// the bounds and passes ambient through. Items enter a registered front end and a
// two-entry queue, and the back end runs one item at a time: a calibrate item with a good
// pair for an existing sensor waits on the 23-step serial divider for the slope, then
// forms the offset in the shared multiplier; a rescale item passes through that multiplier,
// and a calibrate item with a bad pair or an out-of-range sensor goes straight to its ack.
// Results leave through an output register, so the back end moves to the next item once
// the previous result has been transferred or is being transferred.
module two_point_sensor_calibrate_rescale_unit import tpscr_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  cfg_regs_t cfg_q;
  logic      push;
  cmd_t      push_cmd;
  logic      push_ready;
  logic      head_valid;
  cmd_t      head_cmd;
  logic      pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nominal_black <= NOMINAL_BLACK_RESET;
      cfg_q.nominal_white <= NOMINAL_WHITE_RESET;
      cfg_q.lower_bound   <= LOWER_BOUND_RESET;
      cfg_q.upper_bound   <= UPPER_BOUND_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NOMINAL_BLACK: cfg_q.nominal_black <= cfg_data_i;
        CFG_NOMINAL_WHITE: cfg_q.nominal_white <= cfg_data_i;
        CFG_LOWER_BOUND:   cfg_q.lower_bound   <= cfg_data_i;
        CFG_UPPER_BOUND:   cfg_q.upper_bound   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpscr_front #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .push_ready_i(push_ready)
  );

  tpscr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_cmd_o  (head_cmd)
  );

  tpscr_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  tpscr_back #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_cmd_i  (head_cmd),
    .pop_o       (pop),
    .cfg_i       (cfg_q),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
